/* hw/rtl/date_day_distance_top_defines.svh */
// assertion macros for the date distance block
`ifndef DATE_DAY_DISTANCE_TOP_DEFINES_SVH
`define DATE_DAY_DISTANCE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DDD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
`define DDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define DDD_ASSERT_IMPLY(lbl, ante, cons)
`define DDD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/ddd_pkg.sv */
package ddd_pkg;

    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 14;
    localparam int YY_W       = 15;
    localparam int Q4_W       = 13;
    localparam int Q100_W     = 8;
    localparam int RECIP_W    = 16;
    localparam int PROD_W     = Q4_W + RECIP_W;
    localparam int MS_W       = 9;
    localparam int COUNT_W    = 23;
    localparam int DIST_W     = 22;
    localparam int STATUS_W   = 2;
    localparam int YCMP_W     = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // floor(x / 25) = (x * RECIP_25) >> RECIP_SHIFT, exact for x below 43690
    localparam logic [RECIP_W-1:0] RECIP_25    = 16'd41944;
    localparam int                 RECIP_SHIFT = 20;

    localparam logic [YY_W-1:0]    YEAR_OFFSET   = 15'd399;
    localparam logic [COUNT_W-1:0] DAYS_PER_YEAR = 23'd365;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FIRST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SECOND_BAD = 2'd2;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // days before the first of the month in a common year
    function automatic logic [MS_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MS_W-1:0] r;
        begin
            case (m)
                MONTH_FEB: r = 9'd31;
                MONTH_MAR: r = 9'd59;
                MONTH_APR: r = 9'd90;
                MONTH_MAY: r = 9'd120;
                MONTH_JUN: r = 9'd151;
                MONTH_JUL: r = 9'd181;
                MONTH_AUG: r = 9'd212;
                MONTH_SEP: r = 9'd243;
                MONTH_OCT: r = 9'd273;
                MONTH_NOV: r = 9'd304;
                MONTH_DEC: r = 9'd334;
                default:   r = 9'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] r;
        begin
            case (m) inside
                MONTH_FEB:                               r = leap ? 5'd29 : 5'd28;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: r = 5'd30;
                default:                                 r = 5'd31;
            endcase
            return r;
        end
    endfunction

endpackage

/* hw/rtl/ddd_day_count.sv */
module ddd_day_count #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic                        clk,
    input  ddd_pkg::stage_en_t          en,
    input  ddd_pkg::date_t              date,
    output logic                        ok,
    output logic [ddd_pkg::COUNT_W-1:0] count
);
    import ddd_pkg::*;

    // stage 1: offset year and reciprocal products
    logic [DAY_W-1:0]   day1_reg;
    logic [MONTH_W-1:0] month1_reg;
    logic [YEAR_W-1:0]  year1_reg;
    logic [YY_W-1:0]    yy1_reg;
    logic [YY_W-1:0]    yy1_next;
    logic [PROD_W-1:0]  pyy1_reg;
    logic [PROD_W-1:0]  pyy1_next;
    logic [PROD_W-1:0]  py1_reg;
    logic [PROD_W-1:0]  py1_next;

    assign yy1_next  = YY_W'(date.year) + YEAR_OFFSET;
    assign pyy1_next = PROD_W'(yy1_next[YY_W-1:2]) * PROD_W'(RECIP_25);
    assign py1_next  = PROD_W'(date.year[YEAR_W-1:2]) * PROD_W'(RECIP_25);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            day1_reg   <= date.day;
            month1_reg <= date.month;
            year1_reg  <= date.year;
            yy1_reg    <= yy1_next;
            pyy1_reg   <= pyy1_next;
            py1_reg    <= py1_next;
        end
    end

    // stage 2: leap year, date check, year base and in-year offset
    logic [Q100_W-1:0]  q100yy;
    logic [Q100_W-1:0]  q100y;
    logic [11:0]        rem25;
    logic               leap;
    logic               ok2_next;
    logic               ok2_reg;
    logic [COUNT_W-1:0] base2_next;
    logic [COUNT_W-1:0] base2_reg;
    logic [Q4_W-1:0]    off2_next;
    logic [Q4_W-1:0]    off2_reg;

    always_comb
    begin
        q100yy = pyy1_reg[RECIP_SHIFT +: Q100_W];
        q100y  = py1_reg[RECIP_SHIFT +: Q100_W];
        rem25  = 12'(year1_reg[YEAR_W-1:2]) - 12'(q100y) * 12'd25;
        leap   = (year1_reg[1:0] == 2'd0) && ((rem25 != 12'd0) || (q100y[1:0] == 2'd0));
        ok2_next = (YCMP_W'(year1_reg) <= YCMP_W'(MAX_YEAR))
                && (month1_reg >= MONTH_JAN) && (month1_reg <= MONTH_DEC)
                && (day1_reg != '0) && (day1_reg <= month_length(month1_reg, leap));
        base2_next = COUNT_W'(yy1_reg) * DAYS_PER_YEAR;
        off2_next  = Q4_W'(yy1_reg[YY_W-1:2]) - Q4_W'(q100yy) + Q4_W'(q100yy[Q100_W-1:2])
                   + Q4_W'(month_start(month1_reg))
                   + Q4_W'(leap && (month1_reg > MONTH_FEB))
                   + Q4_W'(day1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            ok2_reg   <= ok2_next;
            base2_reg <= base2_next;
            off2_reg  <= off2_next;
        end
    end

    // stage 3: final day count
    logic               ok3_reg;
    logic [COUNT_W-1:0] count3_reg;
    logic [COUNT_W-1:0] count3_next;

    assign count3_next = base2_reg + COUNT_W'(off2_reg);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            ok3_reg    <= ok2_reg;
            count3_reg <= count3_next;
        end
    end

    assign ok    = ok3_reg;
    assign count = count3_reg;

endmodule

/* hw/rtl/ddd_result.sv */
module ddd_result (
    input  logic                         clk,
    input  logic                         load,
    input  logic                         ok_a,
    input  logic                         ok_b,
    input  logic [ddd_pkg::COUNT_W-1:0]  count_a,
    input  logic [ddd_pkg::COUNT_W-1:0]  count_b,
    output logic [ddd_pkg::STATUS_W-1:0] status,
    output logic [ddd_pkg::DIST_W-1:0]   distance_days
);
    import ddd_pkg::*;

    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DIST_W-1:0]   dist_reg;
    logic [DIST_W-1:0]   dist_next;
    logic [COUNT_W-1:0]  diff;

    always_comb
    begin
        diff = (count_a >= count_b) ? (count_a - count_b) : (count_b - count_a);
        if (!ok_a)
        begin
            status_next = STATUS_FIRST_BAD;
            dist_next   = '0;
        end
        else if (!ok_b)
        begin
            status_next = STATUS_SECOND_BAD;
            dist_next   = '0;
        end
        else
        begin
            status_next = STATUS_OK;
            dist_next   = diff[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            dist_reg   <= dist_next;
        end
    end

    assign status        = status_reg;
    assign distance_days = dist_reg;

endmodule

/* hw/rtl/date_day_distance_top.sv */
// channel   dir  tdata fields, lowest bit up
// s_axis    in   first_day[4:0] first_month[8:5] first_year[22:9]
//                second_day[27:23] second_month[31:28] second_year[45:32], zero [47:46]
// m_axis    out  status[1:0] distance_days[23:2]
//
// one transaction per cycle sustained while m_axis_tready stays high
// three stages per date (products, check and year base, day count), then the result register
// each stage loads when it is empty or the next one moves, so bubbles fill during a stall
// a stalled result holds and nothing is dropped or repeated
// rst_n clears only the stage and result valid bits
module date_day_distance_top #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // first_day, first_month, first_year, second_day, second_month, second_year
    input  logic [ddd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status, distance_days
    output logic [ddd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ddd_pkg::*;

`include "date_day_distance_top_defines.svh"

    logic      v1_reg, v1_next;
    logic      v2_reg, v2_next;
    logic      v3_reg, v3_next;
    logic      vout_reg, vout_next;
    logic      load_out;
    stage_en_t en;
    date_t     date_a;
    date_t     date_b;
    logic      ok_a, ok_b;
    logic [COUNT_W-1:0]  count_a, count_b;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance_days;
    logic      s_fire;

    always_comb
    begin
        load_out = !vout_reg || m_axis_tready;
        en.s3    = !v3_reg || load_out;
        en.s2    = !v2_reg || en.s3;
        en.s1    = !v1_reg || en.s2;
        s_fire   = s_axis_tvalid && en.s1;
        v1_next   = en.s1 ? s_axis_tvalid : v1_reg;
        v2_next   = en.s2 ? v1_reg : v2_reg;
        v3_next   = en.s3 ? v2_reg : v3_reg;
        vout_next = load_out ? v3_reg : vout_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            v3_reg   <= v3_next;
            vout_reg <= vout_next;
        end
    end

    assign date_a.day   = s_axis_tdata[4:0];
    assign date_a.month = s_axis_tdata[8:5];
    assign date_a.year  = s_axis_tdata[22:9];
    assign date_b.day   = s_axis_tdata[27:23];
    assign date_b.month = s_axis_tdata[31:28];
    assign date_b.year  = s_axis_tdata[45:32];

    ddd_day_count #(
        .MAX_YEAR(MAX_YEAR)
    ) u_count_a (
        .clk  (clk),
        .en   (en),
        .date (date_a),
        .ok   (ok_a),
        .count(count_a)
    );

    ddd_day_count #(
        .MAX_YEAR(MAX_YEAR)
    ) u_count_b (
        .clk  (clk),
        .en   (en),
        .date (date_b),
        .ok   (ok_b),
        .count(count_b)
    );

    ddd_result u_result (
        .clk          (clk),
        .load         (load_out),
        .ok_a         (ok_a),
        .ok_b         (ok_b),
        .count_a      (count_a),
        .count_b      (count_b),
        .status       (status),
        .distance_days(distance_days)
    );

    assign s_axis_tready = en.s1;
    assign m_axis_tvalid = vout_reg;
    assign m_axis_tdata  = {distance_days, status};

    `DDD_ASSERT_IMPLY(a_empty_out_ready, !vout_reg, s_axis_tready)
    `DDD_ASSERT_IMPLY(a_full_stall_blocks, vout_reg && !m_axis_tready && v1_reg && v2_reg && v3_reg, !s_axis_tready)
    `DDD_ASSERT_NEXT(a_accept_enters, s_fire, v1_reg)
    `DDD_ASSERT_IMPLY(a_bad_zero_dist, vout_reg && (status != STATUS_OK), distance_days == '0)

endmodule

/* bench/date_day_distance_top_tb.sv */
`timescale 1ns / 1ps

module date_day_distance_top_tb;

    import ddd_pkg::*;

    localparam int unsigned MAX_YEAR = 9999;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          MAX_REPORTS = 10;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DIST_W-1:0]   days;
    } distance_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    distance_result_t expected_distances[$];
    distance_result_t oldest;
    logic [STATUS_W-1:0] seen_status;
    logic [DIST_W-1:0]   seen_days;
    int error_count;
    int send_idle_pct;
    int recv_stall_pct;

    date_day_distance_top #(
        .MAX_YEAR(MAX_YEAR)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned days_in_month(input logic [MONTH_W-1:0] m,
                                                  input int unsigned y);
        case (m)
            MONTH_FEB: return is_leap_year(y) ? 29 : 28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
            default: return 31;
        endcase
    endfunction

    function automatic int unsigned days_before_month(input logic [MONTH_W-1:0] m);
        case (m)
            MONTH_JAN: return 0;
            MONTH_FEB: return 31;
            MONTH_MAR: return 59;
            MONTH_APR: return 90;
            MONTH_MAY: return 120;
            MONTH_JUN: return 151;
            MONTH_JUL: return 181;
            MONTH_AUG: return 212;
            MONTH_SEP: return 243;
            MONTH_OCT: return 273;
            MONTH_NOV: return 304;
            MONTH_DEC: return 334;
            default: return 0;
        endcase
    endfunction

    function automatic bit date_is_valid(input logic [DAY_W-1:0] d,
                                         input logic [MONTH_W-1:0] m,
                                         input logic [YEAR_W-1:0] y);
        if (y > MAX_YEAR)
            return 1'b0;
        if (m < MONTH_JAN || m > MONTH_DEC)
            return 1'b0;
        if (d < 1 || d > days_in_month(m, y))
            return 1'b0;
        return 1'b1;
    endfunction

    // day number on a scale shifted by one 400-year cycle so year zero stays positive
    function automatic longint unsigned day_number(input logic [DAY_W-1:0] d,
                                                   input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0] y);
        longint unsigned yy;
        longint unsigned n;
        yy = longint'(y) + 399;
        n = 365 * yy + yy / 4 - yy / 100 + yy / 400;
        n += days_before_month(m);
        if (m > MONTH_FEB && is_leap_year(y))
            n += 1;
        return n + d;
    endfunction

    function automatic distance_result_t predict_distance(input logic [DAY_W-1:0] d1,
                                                          input logic [MONTH_W-1:0] m1,
                                                          input logic [YEAR_W-1:0] y1,
                                                          input logic [DAY_W-1:0] d2,
                                                          input logic [MONTH_W-1:0] m2,
                                                          input logic [YEAR_W-1:0] y2);
        distance_result_t r;
        longint unsigned a;
        longint unsigned b;
        longint unsigned diff;
        r.status = STATUS_OK;
        r.days = '0;
        if (!date_is_valid(d1, m1, y1))
            r.status = STATUS_FIRST_BAD;
        else if (!date_is_valid(d2, m2, y2))
            r.status = STATUS_SECOND_BAD;
        else
        begin
            a = day_number(d1, m1, y1);
            b = day_number(d2, m2, y2);
            diff = (a >= b) ? a - b : b - a;
            r.days = diff[DIST_W-1:0];
        end
        return r;
    endfunction

    task automatic send_dates(input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1,
                              input logic [YEAR_W-1:0] y1, input logic [DAY_W-1:0] d2,
                              input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, y2, m2, d2, y1, m1, d1};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_distances.push_back(predict_distance(d1, m1, y1, d2, m2, y2));
        @(negedge clk);
    endtask

    task automatic pick_year(output logic [YEAR_W-1:0] y);
        case ($urandom_range(9))
            0: y = YEAR_W'($urandom_range(0, 24) * 400 + $urandom_range(0, 3) * 100);
            1: y = YEAR_W'($urandom_range(0, 4));
            2: y = YEAR_W'(MAX_YEAR - $urandom_range(0, 4));
            3, 4: y = YEAR_W'($urandom_range(1890, 2110));
            default: y = YEAR_W'($urandom_range(0, MAX_YEAR));
        endcase
    endtask

    task automatic pick_valid_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
                                   output logic [YEAR_W-1:0] y, input bit edge_heavy);
        int unsigned len;
        pick_year(y);
        m = edge_heavy && $urandom_range(2) == 0 ? MONTH_FEB
                                                  : MONTH_W'($urandom_range(1, 12));
        len = days_in_month(m, y);
        case ($urandom_range(edge_heavy ? 3 : 9))
            0: d = DAY_W'(len);
            1: d = DAY_W'(1);
            2: d = DAY_W'(len - 1);
            default: d = DAY_W'($urandom_range(1, len));
        endcase
    endtask

    // one field at a time made out of range, or all fields raw
    task automatic pick_broken_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m,
                                    output logic [YEAR_W-1:0] y);
        pick_valid_date(d, m, y, 1'b0);
        case ($urandom_range(5))
            0: d = '0;
            1: d = DAY_W'($urandom_range(days_in_month(m, y) + 1, 31));
            2: m = $urandom_range(1) ? '0 : MONTH_W'($urandom_range(13, 15));
            3: y = YEAR_W'($urandom_range(MAX_YEAR + 1, (1 << YEAR_W) - 1));
            default:
            begin
                d = DAY_W'($urandom);
                m = MONTH_W'($urandom);
                y = YEAR_W'($urandom);
            end
        endcase
    endtask

    task automatic send_random_pairs(input int count, input int broken_pct, input bit edge_heavy);
        logic [DAY_W-1:0]   d1, d2;
        logic [MONTH_W-1:0] m1, m2;
        logic [YEAR_W-1:0]  y1, y2;
        for (int i = 0; i < count; i++)
        begin
            pick_valid_date(d1, m1, y1, edge_heavy);
            pick_valid_date(d2, m2, y2, edge_heavy);
            if ($urandom_range(99) < broken_pct)
            begin
                case ($urandom_range(2))
                    0: pick_broken_date(d1, m1, y1);
                    1: pick_broken_date(d2, m2, y2);
                    default:
                    begin
                        pick_broken_date(d1, m1, y1);
                        pick_broken_date(d2, m2, y2);
                    end
                endcase
            end
            send_dates(d1, m1, y1, d2, m2, y2);
        end
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_distances.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed_dates();
        send_dates(1, MONTH_JAN, 0, 31, MONTH_DEC, YEAR_W'(MAX_YEAR));
        send_dates(31, MONTH_DEC, YEAR_W'(MAX_YEAR), 1, MONTH_JAN, 0);
        send_dates(15, MONTH_JUN, 2024, 15, MONTH_JUN, 2024);
        send_dates(29, MONTH_FEB, 2000, 1, MONTH_MAR, 1900);
        send_dates(29, MONTH_FEB, 0, 31, MONTH_DEC, 0);
        send_dates(29, MONTH_FEB, 2004, 28, MONTH_FEB, 2003);
        send_dates(31, MONTH_DEC, 1, 1, MONTH_JAN, 2);
        send_dates(29, MONTH_FEB, 1900, 1, MONTH_JAN, 2000);
        send_dates(1, MONTH_JAN, 2000, 29, MONTH_FEB, 2100);
        send_dates(1, 0, 2000, 1, MONTH_JAN, 2000);
        send_dates(1, MONTH_JAN, 2000, 1, 13, 2000);
        send_dates(1, 15, 2000, 1, 0, 2000);
        send_dates(0, MONTH_MAR, 2000, 1, MONTH_MAR, 2000);
        send_dates(1, MONTH_MAR, 2000, 0, MONTH_MAR, 2000);
        send_dates(31, MONTH_APR, 2000, 30, MONTH_APR, 2000);
        send_dates(30, MONTH_APR, 2000, 31, MONTH_SEP, 2000);
        send_dates(31, MONTH_JAN, YEAR_W'(MAX_YEAR + 1), 1, MONTH_JAN, 1);
        send_dates(1, MONTH_JAN, 1, 31, MONTH_JAN, YEAR_W'((1 << YEAR_W) - 1));
        send_dates(31, 15, YEAR_W'((1 << YEAR_W) - 1), 31, 15, YEAR_W'((1 << YEAR_W) - 1));
        send_dates(0, 0, 0, 0, 0, 0);
        send_dates(30, MONTH_NOV, 8191, 31, MONTH_OCT, 8192);
        send_dates(29, MONTH_FEB, 9996, 31, MONTH_JUL, 4095);
    endtask

    task automatic test_random_dates();
        send_random_pairs(550, 15, 1'b0);
    endtask

    task automatic test_back_to_back();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_pairs(250, 15, 1'b0);
        wait_until_drained();
        send_idle_pct = 25;
        recv_stall_pct = 25;
    endtask

    task automatic test_month_ends();
        send_random_pairs(250, 10, 1'b1);
    endtask

    task automatic test_invalid_dates();
        send_random_pairs(300, 60, 1'b0);
    endtask

    always @(negedge clk)
        m_axis_tready <= rst_n && $urandom_range(99) >= recv_stall_pct;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_status = m_axis_tdata[STATUS_W-1:0];
            seen_days = m_axis_tdata[STATUS_W +: DIST_W];
            if (expected_distances.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected transaction, status %0d distance %0d",
                             $realtime, seen_status, seen_days);
            end
            else
            begin
                oldest = expected_distances.pop_front();
                if (oldest.status !== seen_status || oldest.days !== seen_days)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: mismatch, expected status %0d distance %0d, got status %0d distance %0d",
                                 $realtime, oldest.status, oldest.days, seen_status, seen_days);
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        send_idle_pct = 25;
        recv_stall_pct = 25;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_dates();
        test_random_dates();
        test_back_to_back();
        test_month_ends();
        test_invalid_dates();

        s_axis_tvalid <= 1'b0;
        while (expected_distances.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ddd_pkg.sv
hw/rtl/ddd_day_count.sv
hw/rtl/ddd_result.sv
hw/rtl/date_day_distance_top.sv
bench/date_day_distance_top_tb.sv
